// ===== rtl/core/pdp_pkg.sv =====
package pdp_pkg;

    localparam int CHAR_W       = 8;
    localparam int MASK_W       = 26;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = MASK_W;
    localparam int MAX_RES      = 4;
    localparam int RES_CNT_W    = $clog2(MAX_RES + 1);
    localparam int RES_IDX_W    = $clog2(MAX_RES);

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] LETTER_A   = 8'h41;
    localparam logic [CHAR_W-1:0] LETTER_Z   = 8'h5A;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHABET_MASK  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REPLACE_LETTER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FILLER_LETTER  = 2'd2;

    localparam logic [MASK_W-1:0] ALPHABET_MASK_RST  = 26'h3FFFDFF;
    localparam logic [CHAR_W-1:0] REPLACE_LETTER_RST = 8'h49;
    localparam logic [CHAR_W-1:0] FILLER_LETTER_RST  = 8'h58;

    typedef logic [CHAR_W-1:0] char_t;

endpackage

// ===== rtl/core/playfair_digraph_prepare.sv =====
// Latency: a request's first result is on the output the cycle after it is accepted.
// Throughput: one request per cycle while each yields at most one result and the output
// does not hold off; a request that yields more results (up to four) stalls the input
// after it is accepted, also while the output is held off, until its last result is taken.
// Reset: rst_n is asynchronous, active low; it clears the pairing state, empties the result
// buffer and loads the default alphabet mask, replacement and filler letters.
module playfair_digraph_prepare
    import pdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] message_char
    input  logic                  s_tlast,   // message_end
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_char
    output logic [0:0]            m_tuser,   // [0] has_char
    output logic                  m_tlast,   // end_of_message
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [MASK_W-1:0]    alphabet_mask_reg;
    char_t                replace_letter_reg;
    char_t                filler_letter_reg;

    logic                 pend_valid_reg, pend_valid_next;
    char_t                pend_char_reg, pend_char_next;
    logic                 odd_reg, odd_next;

    char_t                slot_reg [MAX_RES];
    char_t                slot_next [MAX_RES];
    logic [RES_CNT_W-1:0] rem_reg, rem_next;
    logic [RES_IDX_W-1:0] pos_reg;
    logic                 has_reg, has_next;
    logic                 end_reg;

    logic                 accept;
    logic                 take;
    char_t                in_char;
    char_t                filt_char;
    logic                 is_space;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_mask_reg  <= ALPHABET_MASK_RST;
            replace_letter_reg <= REPLACE_LETTER_RST;
            filler_letter_reg  <= FILLER_LETTER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ALPHABET_MASK:  alphabet_mask_reg  <= cfg_wdata;
                REG_REPLACE_LETTER: replace_letter_reg <= cfg_wdata[CHAR_W-1:0];
                REG_FILLER_LETTER:  filler_letter_reg  <= cfg_wdata[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_char  = s_tdata;
    assign is_space = (in_char == SPACE_CHAR);

    always_comb
    begin
        logic [4:0] letter_idx;
        letter_idx = 5'(in_char - LETTER_A);
        filt_char  = replace_letter_reg;
        if (in_char inside {[LETTER_A:LETTER_Z]})
        begin
            if (alphabet_mask_reg[letter_idx])
                filt_char = in_char;
        end
    end

    // build the burst of results for one request
    always_comb
    begin
        logic                 held_valid;
        char_t                held_char;
        logic                 odd;
        logic [RES_CNT_W-1:0] n;

        held_valid = pend_valid_reg;
        held_char  = pend_char_reg;
        n          = '0;
        for (int i = 0; i < MAX_RES; i++)
            slot_next[i] = '0;

        if (!is_space)
        begin
            if (!pend_valid_reg)
            begin
                held_valid = 1'b1;
                held_char  = filt_char;
            end
            else
            begin
                slot_next[n[RES_IDX_W-1:0]] = pend_char_reg;
                n = n + 1'b1;
                if (pend_char_reg == filt_char)
                begin
                    slot_next[n[RES_IDX_W-1:0]] = filler_letter_reg;
                    n = n + 1'b1;
                end
                slot_next[n[RES_IDX_W-1:0]] = filt_char;
                n = n + 1'b1;
                held_valid = 1'b0;
                held_char  = '0;
            end
        end

        odd      = odd_reg ^ n[0];
        has_next = 1'b1;

        if (s_tlast)
        begin
            if (held_valid)
            begin
                slot_next[n[RES_IDX_W-1:0]] = held_char;
                n = n + 1'b1;
                odd = ~odd;
                held_valid = 1'b0;
                held_char  = '0;
            end
            if (odd)
            begin
                slot_next[n[RES_IDX_W-1:0]] = filler_letter_reg;
                n = n + 1'b1;
            end
            // empty ending: a bare end marker
            if (n == '0)
            begin
                has_next = 1'b0;
                n = RES_CNT_W'(1);
            end
            odd = 1'b0;
        end

        pend_valid_next = held_valid;
        pend_char_next  = held_char;
        odd_next        = odd;
        rem_next        = n;
    end

    assign take     = m_tvalid && m_tready;
    assign s_tready = (rem_reg == '0) || ((rem_reg == RES_CNT_W'(1)) && m_tready);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_char_reg  <= '0;
            odd_reg        <= 1'b0;
            rem_reg        <= '0;
            pos_reg        <= '0;
            has_reg        <= 1'b0;
            end_reg        <= 1'b0;
        end
        else if (accept)
        begin
            pend_valid_reg <= pend_valid_next;
            pend_char_reg  <= pend_char_next;
            odd_reg        <= odd_next;
            rem_reg        <= rem_next;
            pos_reg        <= '0;
            has_reg        <= has_next;
            end_reg        <= s_tlast;
        end
        else if (take)
        begin
            rem_reg <= rem_reg - 1'b1;
            pos_reg <= pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_RES; i++)
                slot_reg[i] <= slot_next[i];
        end
    end

    assign m_tvalid   = (rem_reg != '0);
    assign m_tdata    = slot_reg[pos_reg];
    assign m_tuser[0] = has_reg;
    assign m_tlast    = end_reg && (rem_reg == RES_CNT_W'(1));

endmodule

// ===== rtl/core/pdp_checker.sv =====
module pdp_checker
    import pdp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a bare end marker is always the final result of its message
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("bare marker without end of message");

    // a bare end marker carries a zero character
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("bare marker with nonzero character");

    // input only backs up behind pending results
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind playfair_digraph_prepare pdp_checker u_pdp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/digraph_checker.sv =====
`timescale 1ns / 1ps

module digraph_checker
    import pdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] message_char
    input  logic                  s_tlast,   // message_end
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,   // [7:0] out_char
    input  logic [0:0]            m_tuser,   // [0] has_char
    input  logic                  m_tlast,   // end_of_message
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    awaited,
    output int                    results_seen
);

    typedef struct packed {
        char_t ch;
        logic  has;
        logic  eom;
    } prep_char_t;

    logic [MASK_W-1:0] alpha_mask;
    char_t             subst_char;
    char_t             fill_char;

    logic              held_valid;
    char_t             held_char;
    logic              odd_count;

    prep_char_t        prepared_q[$];
    prep_char_t        step_out[$];

    assign awaited = prepared_q.size();

    function automatic char_t filter_char(input char_t c);
        if (c >= LETTER_A && c <= LETTER_Z && alpha_mask[c - LETTER_A])
            return c;
        return subst_char;
    endfunction

    task automatic emit_char(input char_t ch, input logic has);
        step_out.push_back('{ch: ch, has: has, eom: 1'b0});
        if (has)
            odd_count = !odd_count;
    endtask

    task automatic predict_digraphs(input char_t raw, input logic last);
        char_t c;
        c = raw;
        step_out.delete();
        if (c != SPACE_CHAR)
        begin
            c = filter_char(c);
            if (!held_valid)
            begin
                held_valid = 1'b1;
                held_char  = c;
            end
            else
            begin
                emit_char(held_char, 1'b1);
                if (held_char == c)
                    emit_char(fill_char, 1'b1);
                emit_char(c, 1'b1);
                held_valid = 1'b0;
                held_char  = '0;
            end
        end
        if (last)
        begin
            if (held_valid)
            begin
                emit_char(held_char, 1'b1);
                held_valid = 1'b0;
                held_char  = '0;
            end
            if (odd_count)
                emit_char(fill_char, 1'b1);
            // nothing left to emit: bare end marker
            if (step_out.size() == 0)
                emit_char('0, 1'b0);
            step_out[step_out.size() - 1].eom = 1'b1;
            odd_count = 1'b0;
        end
        foreach (step_out[i])
            prepared_q.push_back(step_out[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        prep_char_t want;
        if (!rst_n)
        begin
            alpha_mask   = ALPHABET_MASK_RST;
            subst_char   = REPLACE_LETTER_RST;
            fill_char    = FILLER_LETTER_RST;
            held_valid   = 1'b0;
            held_char    = '0;
            odd_count    = 1'b0;
            fail_count   = 0;
            results_seen = 0;
            prepared_q.delete();
        end
        else
        begin
            // request first: a write in the same cycle only affects later requests
            if (s_tvalid && s_tready)
                predict_digraphs(s_tdata, s_tlast);
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_ALPHABET_MASK:  alpha_mask = cfg_wdata[MASK_W-1:0];
                    REG_REPLACE_LETTER: subst_char = cfg_wdata[CHAR_W-1:0];
                    REG_FILLER_LETTER:  fill_char  = cfg_wdata[CHAR_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (prepared_q.size() == 0)
                begin
                    $error("unexpected result: out_char %h has_char %b end_of_message %b",
                           m_tdata, m_tuser[0], m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = prepared_q.pop_front();
                    if (m_tdata !== want.ch)
                    begin
                        $error("out_char: expected %h, got %h", want.ch, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.has)
                    begin
                        $error("has_char: expected %b, got %b", want.has, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tlast !== want.eom)
                    begin
                        $error("end_of_message: expected %b, got %b", want.eom, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pdp_pkg::*;

    // index past the last register; writes to it must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 25;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int   fail_count;
    int   awaited;
    int   results_seen;
    int   sent_count  = 0;
    int   msg_count   = 0;
    int   cfg_count   = 0;
    int   idle_cycles = 0;
    bit   no_idle     = 1'b0;
    bit   hold_ask    = 1'b0;
    bit   hold_done   = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    playfair_digraph_prepare DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    digraph_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .awaited      (awaited),
        .results_seen (results_seen)
    );

    // watchdog: no request and no result accepted for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin : sink
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_ask && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    task automatic send_req(input char_t ch, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
        if (last)
            msg_count++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_req(char_t'(txt[i]), i == txt.len() - 1);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        // an item with no result may still be inside the block
        repeat (3) @(posedge clk);
    endtask

    // the spare index gets junk first, then the three real registers
    task automatic load_settings(input logic [MASK_W-1:0] mask, input char_t repl,
                                 input char_t fill);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_SPARE;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_addr  <= REG_ALPHABET_MASK;
        cfg_wdata <= mask;
        @(posedge clk);
        cfg_addr  <= REG_REPLACE_LETTER;
        cfg_wdata <= CFG_DATA_W'(repl);
        @(posedge clk);
        cfg_addr  <= REG_FILLER_LETTER;
        cfg_wdata <= CFG_DATA_W'(fill);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_count++;
    endtask

    function automatic char_t pick_char(input char_t prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return char_t'(LETTER_A + $urandom_range(0, 25));
        else if (r < 75)
            return prev;      // makes doubled pairs likely
        else if (r < 85)
            return SPACE_CHAR;
        return char_t'($urandom_range(0, 255));
    endfunction

    function automatic char_t pick_setting_char;
        if ($urandom_range(0, 1))
            return char_t'(LETTER_A + $urandom_range(0, 25));
        return char_t'($urandom_range(0, 255));
    endfunction

    initial
    begin : stimulus
        int                phase_start;
        int                len;
        char_t             prev;
        char_t             c;
        logic [MASK_W-1:0] mask;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset
        send_text("LL");
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b0);
        send_req("J", 1'b0);
        send_req("A", 1'b0);
        send_req(SPACE_CHAR, 1'b0);
        send_req("Z", 1'b1);
        send_text(" ");
        send_text("Q");
        send_text("ab c");
        send_text("AB ");
        drain();

        // empty alphabet, space as stand-in, zero filler
        load_settings('0, SPACE_CHAR, 8'h00);
        send_text("AB");
        send_text("K ");
        drain();

        load_settings({MASK_W{1'b1}}, 8'hFF, 8'hFF);
        send_text("JJ");
        send_req(8'hFF, 1'b1);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            if ($urandom_range(0, 1))
                mask = MASK_W'($urandom);
            else
                mask = {MASK_W{1'b1}} ^ (MASK_W'(1) << $urandom_range(0, MASK_W - 1));
            load_settings(mask, pick_setting_char(), pick_setting_char());
            if (phase == 1)
                hold_ask = 1'b1;
            no_idle = (phase == 2);
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_ITEMS)
            begin
                len  = $urandom_range(1, 8);
                prev = char_t'(LETTER_A + $urandom_range(0, 25));
                for (int i = 0; i < len; i++)
                begin
                    c = pick_char(prev);
                    send_req(c, i == len - 1);
                    prev = c;
                end
            end
            drain();
        end
        no_idle = 1'b0;

        $display("tb: %0d requests in %0d messages under %0d register loads",
                 sent_count, msg_count, cfg_count);
        $display("tb: %0d results compared, with one long output hold-off", results_seen);
        if (fail_count == 0 && awaited == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pdp_pkg.sv
rtl/core/playfair_digraph_prepare.sv
rtl/core/pdp_checker.sv
tb/digraph_checker.sv
tb/tb.sv
